>>> rtl/core/psc_pkg.sv
// Shared types and constants for the plastic conductance synapse.
// Used by psc_mul and plastic_synapse_conductance_top; depends on nothing.
`default_nettype none

package psc_pkg;

  // STDP window in ticks; the loop counter is sized from it
  localparam int STDP_WINDOW = 255;
  localparam int LOOP_W      = $clog2(STDP_WINDOW + 1);

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [MUL_P_W-1:0] mul_p_t;

  // Q16 constants
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [9:0]  DEP_RECOVER = 10'd655;
  localparam logic [11:0] FAC_DECAY   = 12'd3277;
  localparam logic [17:0] WEIGHT_MAX  = 18'd131072;
  localparam logic [17:0] DRIVE_MAX   = 18'h3FFFF;
  localparam logic signed [47:0] CUR_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] CUR_MIN = {1'b1, {47{1'b0}}};

  // commands
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PRE  = 2'd1,
    CMD_PAIR = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // plasticity modes (codes 5..7 behave as none)
  localparam logic [2:0] MODE_NONE = 3'd0;
  localparam logic [2:0] MODE_FAC  = 3'd1;
  localparam logic [2:0] MODE_DEP  = 3'd2;
  localparam logic [2:0] MODE_DYN  = 3'd3;
  localparam logic [2:0] MODE_STDP = 3'd4;

  // register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_DELAY    = 3'd1;
  localparam logic [2:0] REG_CONTACTS = 3'd2;
  localparam logic [2:0] REG_REVERSAL = 3'd3;
  localparam logic [2:0] REG_G_DECAY  = 3'd4;
  localparam logic [2:0] REG_GAIN_P   = 3'd5;
  localparam logic [2:0] REG_GAIN_M   = 3'd6;
  localparam logic [2:0] REG_S_DECAY  = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_REL,
    S_COND,
    S_CONDW,
    S_DEPW,
    S_FACW,
    S_CURW,
    S_PRE,
    S_W1,
    S_W1W,
    S_W2W,
    S_STDP,
    S_LOOP,
    S_DW,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/psc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on psc_pkg for operand and product widths.
`default_nettype none

module psc_mul (
  input  wire logic            clk,
  input  wire psc_pkg::mul_a_t mul_a,
  input  wire psc_pkg::mul_b_t mul_b,
  output psc_pkg::mul_p_t      mul_p_r
);
  import psc_pkg::*;

  mul_p_t mul_p_nxt;

  assign mul_p_nxt = mul_p_t'(mul_a) * mul_p_t'(mul_b);

  always_ff @(posedge clk) begin
    mul_p_r <= mul_p_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/plastic_synapse_conductance_top.sv
// Plastic conductance synapse: tick, pre-spike and STDP pair commands, one result per item.
// A tick takes longer on a release; a pair command's run grows with |gap| (bounded by
// STDP_WINDOW); command 3 and a rejected pair go straight to the result.
// One item at a time on one shared 34x18 multiplier (psc_mul); the next item is
// accepted in the cycle after its result loads, with no overlap between items.
// Reset (synchronous, rst_n low) loads register defaults and state; needs psc_pkg, psc_mul.
`default_nettype none

module plastic_synapse_conductance_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input item channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic signed [15:0] in_post_voltage,
  input  wire logic signed [15:0] in_spike_gap,
  // result item channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [47:0]      out_synaptic_current,
  output logic [17:0]             out_effective_weight,
  output logic [17:0]             out_base_weight,
  // APB-style register port
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [4:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import psc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0]         mode_r;
  logic [7:0]         delay_r;
  logic [7:0]         contacts_r;
  logic signed [15:0] reversal_r;
  logic [15:0]        g_decay_r;
  logic [15:0]        gain_p_r;
  logic [15:0]        gain_m_r;
  logic [15:0]        s_decay_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NONE;
      delay_r    <= 8'd15;
      contacts_r <= 8'd1;
      reversal_r <= 16'sd0;
      g_decay_r  <= 16'd64238;
      gain_p_r   <= 16'd328;
      gain_m_r   <= 16'd328;
      s_decay_r  <= 16'd65209;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:     mode_r     <= cfg_pwdata[2:0];
        REG_DELAY:    delay_r    <= cfg_pwdata[7:0];
        REG_CONTACTS: contacts_r <= cfg_pwdata[7:0];
        REG_REVERSAL: reversal_r <= cfg_pwdata[15:0];
        REG_G_DECAY:  g_decay_r  <= cfg_pwdata[15:0];
        REG_GAIN_P:   gain_p_r   <= cfg_pwdata[15:0];
        REG_GAIN_M:   gain_m_r   <= cfg_pwdata[15:0];
        REG_S_DECAY:  s_decay_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:     cfg_prdata = 32'(mode_r);
      REG_DELAY:    cfg_prdata = 32'(delay_r);
      REG_CONTACTS: cfg_prdata = 32'(contacts_r);
      REG_REVERSAL: cfg_prdata = {16'd0, reversal_r};
      REG_G_DECAY:  cfg_prdata = 32'(g_decay_r);
      REG_GAIN_P:   cfg_prdata = 32'(gain_p_r);
      REG_GAIN_M:   cfg_prdata = 32'(gain_m_r);
      REG_S_DECAY:  cfg_prdata = 32'(s_decay_r);
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // mode 3 uses both short-term terms; 5..7 fall through as none
  logic use_fac;
  logic use_dep;
  assign use_fac = (mode_r == MODE_FAC) || (mode_r == MODE_DYN);
  assign use_dep = (mode_r == MODE_DEP) || (mode_r == MODE_DYN);

  // ---------------------------------------------------------------------------
  // Synapse state and sequencer registers
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [7:0]  cnt_r,   cnt_nxt;    // release countdown
  logic [31:0] cond_r,  cond_nxt;   // conductance, Q16.16
  logic [16:0] fac_r,   fac_nxt;    // facilitation, Q1.16
  logic [16:0] dep_r,   dep_nxt;    // depression, Q1.16
  logic [17:0] long_r,  long_nxt;   // base weight, Q2.16
  logic [17:0] drive_r, drive_nxt;  // effective weight, Q2.16

  // per-item payload latched at accept, and the STDP loop counter
  logic signed [15:0] volt_r, volt_nxt;
  logic signed [15:0] gap_r,  gap_nxt;
  logic signed [47:0] cur_r,  cur_nxt;
  logic [LOOP_W-1:0]  loop_r, loop_nxt;

  // result register
  logic               out_valid_r;
  logic signed [47:0] out_cur_r;
  logic [17:0]        out_eff_r;
  logic [17:0]        out_base_r;

  // shared multiplier
  mul_a_t mul_a;
  mul_b_t mul_b;
  mul_p_t mul_p_r;

  psc_mul u_mul (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_p_r (mul_p_r)
  );

  logic accept;
  logic out_free;
  logic rel_now;
  logic stdp_go;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;
  assign rel_now  = (cnt_r == 8'd1);     // countdown hits zero on this tick

  // |gap|; the most negative gap maps to 32768 as an unsigned magnitude
  logic [15:0] gap_mag;
  logic [15:0] gap_mag_m1;
  assign gap_mag    = gap_r[15] ? (~gap_r + 16'd1) : gap_r;
  assign gap_mag_m1 = gap_mag - 16'd1;
  assign stdp_go    = (mode_r == MODE_STDP) && (gap_r != 16'sd0) &&
                      (gap_mag <= 16'(STDP_WINDOW));

  // driving force, 17-bit signed
  logic signed [16:0] force_v;
  assign force_v = 17'(reversal_r) - 17'(volt_r);

  // product slices
  logic [32:0] rel_sum;
  logic [16:0] p_q16;     // product >> 16, narrow results
  logic [18:0] p_w;       // product >> 16, weight chain
  logic        cur_fits;
  logic [18:0] up_sum;
  logic [15:0] dw;

  assign rel_sum  = {1'b0, cond_r} + {1'b0, mul_p_r[31:0]};
  assign p_q16    = mul_p_r[32:16];
  assign p_w      = mul_p_r[34:16];
  assign cur_fits = (&mul_p_r[MUL_P_W-1:47]) | ~(|mul_p_r[MUL_P_W-1:47]);
  assign dw       = mul_p_r[31:16];
  assign up_sum   = {1'b0, long_r} + 19'(dw);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(in_command))
            CMD_TICK: state_nxt = S_TICK;
            CMD_PRE:  state_nxt = S_PRE;
            CMD_PAIR: state_nxt = S_STDP;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_TICK:  state_nxt = rel_now ? S_REL : S_COND;
      S_REL:   state_nxt = S_COND;
      S_COND:  state_nxt = S_CONDW;
      S_CONDW: state_nxt = S_DEPW;
      S_DEPW:  state_nxt = S_FACW;
      S_FACW:  state_nxt = S_CURW;
      S_CURW:  state_nxt = S_DONE;
      S_PRE:   state_nxt = S_W1;
      S_W1:    state_nxt = S_W1W;
      S_W1W:   state_nxt = S_W2W;
      S_W2W:   state_nxt = S_DONE;
      S_STDP:  state_nxt = stdp_go ? S_LOOP : S_DONE;
      S_LOOP:  state_nxt = (loop_r == '0) ? S_DW : S_LOOP;
      S_DW:    state_nxt = S_DONE;
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and multiplier operand select. A multiplier state retires the product
  // issued by the state before it, issues the next one, or both.
  // ---------------------------------------------------------------------------
  always_comb begin
    cnt_nxt   = cnt_r;
    cond_nxt  = cond_r;
    fac_nxt   = fac_r;
    dep_nxt   = dep_r;
    long_nxt  = long_r;
    drive_nxt = drive_r;
    volt_nxt  = volt_r;
    gap_nxt   = gap_r;
    cur_nxt   = cur_r;
    loop_nxt  = loop_r;
    mul_a     = '0;
    mul_b     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          volt_nxt = in_post_voltage;
          gap_nxt  = in_spike_gap;
          cur_nxt  = 48'sd0;
        end
      end

      // tick: countdown, maybe release drive * contacts, then decay/recover and compute current
      S_TICK: begin
        if (cnt_r != 8'd0) begin
          cnt_nxt = cnt_r - 8'd1;
        end
        mul_a = MUL_A_W'(drive_r);
        mul_b = MUL_B_W'(contacts_r);
      end
      S_REL: begin
        cond_nxt = rel_sum[32] ? 32'hFFFF_FFFF : rel_sum[31:0];
      end
      S_COND: begin
        mul_a = MUL_A_W'(cond_r);
        mul_b = MUL_B_W'(g_decay_r);
      end
      S_CONDW: begin
        cond_nxt = mul_p_r[47:16];
        mul_a    = MUL_A_W'(ONE_Q16 - dep_r);
        mul_b    = MUL_B_W'(DEP_RECOVER);
      end
      S_DEPW: begin
        if (use_dep) begin
          dep_nxt = dep_r + p_q16;
        end
        mul_a = MUL_A_W'(fac_r);
        mul_b = MUL_B_W'(FAC_DECAY);
      end
      S_FACW: begin
        if (use_fac) begin
          fac_nxt = fac_r - p_q16;
        end
        mul_a = MUL_A_W'(cond_r);
        mul_b = MUL_B_W'(force_v);
      end
      S_CURW: begin
        if (cur_fits) begin
          cur_nxt = mul_p_r[47:0];
        end else begin
          cur_nxt = mul_p_r[MUL_P_W-1] ? CUR_MIN : CUR_MAX;
        end
      end

      // pre spike: restart delay, update short-term terms, rebuild drive
      S_PRE: begin
        cnt_nxt = delay_r;
        if (use_fac) begin
          fac_nxt = fac_r + ((ONE_Q16 - fac_r) >> 1);
        end
        if (use_dep) begin
          dep_nxt = dep_r >> 1;
        end
      end
      S_W1: begin
        mul_a = MUL_A_W'(long_r);
        mul_b = MUL_B_W'(18'(ONE_Q16) + 18'(fac_r));
      end
      S_W1W: begin
        mul_a = MUL_A_W'(p_w);
        mul_b = MUL_B_W'(dep_r);
      end
      S_W2W: begin
        drive_nxt = p_w[18] ? DRIVE_MAX : p_w[17:0];
      end

      // STDP pair: factor = decay^|gap| times gain, one multiply per step, then update base weight
      S_STDP: begin
        loop_nxt = gap_mag_m1[LOOP_W-1:0];
        mul_a    = MUL_A_W'(ONE_Q16);
        mul_b    = MUL_B_W'(s_decay_r);
      end
      S_LOOP: begin
        mul_a = MUL_A_W'(p_q16);
        if (loop_r == '0) begin
          mul_b = MUL_B_W'(gap_r[15] ? gain_m_r : gain_p_r);
        end else begin
          mul_b    = MUL_B_W'(s_decay_r);
          loop_nxt = loop_r - LOOP_W'(1);
        end
      end
      S_DW: begin
        if (!gap_r[15]) begin
          long_nxt = (up_sum > 19'(WEIGHT_MAX)) ? WEIGHT_MAX : up_sum[17:0];
        end else begin
          long_nxt = (18'(dw) >= long_r) ? 18'd0 : (long_r - 18'(dw));
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 8'd0;
      cond_r  <= 32'd0;
      fac_r   <= 17'd0;
      dep_r   <= ONE_Q16;
      long_r  <= 18'(ONE_Q16);
      drive_r <= 18'(ONE_Q16);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cond_r  <= cond_nxt;
      fac_r   <= fac_nxt;
      dep_r   <= dep_nxt;
      long_r  <= long_nxt;
      drive_r <= drive_nxt;
    end
  end

  // item payload and loop counter, no reset needed
  always_ff @(posedge clk) begin
    volt_r <= volt_nxt;
    gap_r  <= gap_nxt;
    cur_r  <= cur_nxt;
    loop_r <= loop_nxt;
  end

  // ---------------------------------------------------------------------------
  // Result register: loaded from S_DONE when the slot is free
  // ---------------------------------------------------------------------------
  logic out_load;
  assign out_load = (state_r == S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cur_r  <= cur_r;
      out_eff_r  <= drive_r;
      out_base_r <= long_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_synaptic_current = out_cur_r;
  assign out_effective_weight = out_eff_r;
  assign out_base_weight      = out_base_r;

endmodule

`default_nettype wire
